>>> src/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg: shared types and constants of the page-table walker
// Item kinds, status codes, result selection and the command and status
// groups that pass between the walk controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

  // Default address width of the table memory, in 64-bit words.
  localparam int MEM_WORD_BITS_DEF = 16;

  // Item kinds carried on the input tuser field.
  localparam logic [1:0] KIND_WRITE     = 2'd0;
  localparam logic [1:0] KIND_TRANSLATE = 2'd1;
  localparam logic [1:0] KIND_UNMAP     = 2'd2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_WINDOW  = 2'd2
  } status_t;

  // How the physical address of a result is formed.
  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_4K   = 2'd1,
    SEL_2M   = 2'd2
  } res_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     latch;      // capture the accepted item
    logic     mem_write;  // write the item's word into the table memory
    logic     rd_root;    // read the PML4 entry through the root pointer
    logic     rd_next;    // read the next entry through the last entry read
    logic [1:0] level;    // walk level of the entry being read
    logic     clr_leaf;   // clear the PT entry read last
    logic     res_load;   // capture the result of the item
    res_sel_t res_sel;
    status_t  res_status;
    logic     out_load;   // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;     // kind of the captured item
    logic       root_win; // root table lies inside the memory
    logic       next_win; // table named by the last entry lies inside
    logic       present;  // present bit of the last entry read
    logic       huge;     // page-size bit of the last entry read
  } sts_t;

endpackage

`default_nettype wire

>>> src/ptw_ctrl.sv
// ----------------------------------------------------------------------------
// ptw_ctrl: walk controller
// Sequences one item at a time through the table walk, one memory read per
// level, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire ptw_pkg::sts_t sts,
  output ptw_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] level_r, level_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    level_nxt      = level_r;
    cmd            = '0;
    cmd.res_sel    = ptw_pkg::SEL_ZERO;
    cmd.res_status = ptw_pkg::ST_OK;
    cmd.level      = level_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_FINISH;
        priority if (sts.kind == ptw_pkg::KIND_WRITE) begin
          cmd.mem_write = 1'b1;
        end else if (sts.kind != ptw_pkg::KIND_TRANSLATE &&
                     sts.kind != ptw_pkg::KIND_UNMAP) begin
          // Unknown kind: result only.
        end else if (!sts.root_win) begin
          cmd.res_status = ptw_pkg::ST_WINDOW;
        end else begin
          cmd.res_load = 1'b0;
          cmd.rd_root  = 1'b1;
          cmd.level    = 2'd0;
          level_nxt    = 2'd0;
          state_nxt    = S_WALK;
        end
      end
      S_WALK: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_FINISH;
        priority if (level_r == 2'd3) begin
          // Leaf PT entry.
          if (sts.kind == ptw_pkg::KIND_UNMAP) begin
            cmd.clr_leaf = 1'b1;
          end else if (sts.present) begin
            cmd.res_sel = ptw_pkg::SEL_4K;
          end else begin
            cmd.res_status = ptw_pkg::ST_MISSING;
          end
        end else if (!sts.present) begin
          cmd.res_status = ptw_pkg::ST_MISSING;
        end else if (level_r == 2'd2 && sts.huge) begin
          // Huge PD entry ends the walk; unmap leaves it alone.
          if (sts.kind == ptw_pkg::KIND_TRANSLATE) begin
            cmd.res_sel = ptw_pkg::SEL_2M;
          end
        end else if (!sts.next_win) begin
          cmd.res_status = ptw_pkg::ST_WINDOW;
        end else begin
          cmd.res_load = 1'b0;
          cmd.rd_next  = 1'b1;
          cmd.level    = level_r + 2'd1;
          level_nxt    = level_r + 2'd1;
          state_nxt    = S_WALK;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid follows loads and downstream takes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/ptw_datapath.sv
// ----------------------------------------------------------------------------
// ptw_datapath: table memory, walk registers and result path
// Holds the table memory with its registered read, the captured item, the
// root pointer and the result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_datapath #(
  parameter int MEM_WORD_BITS = ptw_pkg::MEM_WORD_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [51:0]   cfg_wdata,
  input  wire logic [127:0]  in_tdata,
  input  wire logic [1:0]    in_tuser,
  output logic [55:0]        out_tdata,
  output logic [1:0]         out_tuser,
  input  wire ptw_pkg::cmd_t cmd,
  output ptw_pkg::sts_t      sts
);

  localparam int DEPTH = 1 << MEM_WORD_BITS;

  logic [63:0] mem [DEPTH];

  logic [51:0] root_r;
  logic [1:0]  kind_r;
  logic [15:0] widx_r;
  logic [63:0] wdata_r;
  logic [47:0] va_r;
  logic [63:0] mem_q_r;
  logic [MEM_WORD_BITS-1:0] slot_r;
  logic [51:0] res_phys_r;
  logic [1:0]  res_status_r;
  logic [51:0] out_phys_r;
  logic [1:0]  out_status_r;

  logic [31:0] widx_ext;
  logic        widx_in_range;
  logic [51:0] tbl;
  logic [8:0]  idx;
  logic [48:0] slot_full;
  logic [MEM_WORD_BITS-1:0] rd_slot;
  logic [51:0] res_phys;

  // Write index range check.
  assign widx_ext      = {16'd0, widx_r};
  assign widx_in_range = ((widx_ext >> MEM_WORD_BITS) == 32'd0);

  // A table lies inside the memory when its pointer bits above the
  // memory's table count are all zero.
  assign sts.kind     = kind_r;
  assign sts.root_win = ((root_r >> (MEM_WORD_BITS + 3)) == 52'd0);
  assign sts.next_win = ((mem_q_r[51:0] >> (MEM_WORD_BITS + 3)) == 52'd0);
  assign sts.present  = mem_q_r[0];
  assign sts.huge     = mem_q_r[7];

  // Entry slot of the table being read.
  always_comb begin
    tbl = cmd.rd_root ? root_r : mem_q_r[51:0];
    unique case (cmd.level)
      2'd0:    idx = va_r[47:39];
      2'd1:    idx = va_r[38:30];
      2'd2:    idx = va_r[29:21];
      default: idx = va_r[20:12];
    endcase
    slot_full = {tbl[51:12], idx};
    rd_slot   = slot_full[MEM_WORD_BITS-1:0];
  end

  // Result address.
  always_comb begin
    unique case (cmd.res_sel)
      ptw_pkg::SEL_4K: res_phys = {mem_q_r[51:12], va_r[11:0]};
      ptw_pkg::SEL_2M: res_phys = {mem_q_r[51:21], va_r[20:0]};
      default:         res_phys = 52'd0;
    endcase
  end

  // Table memory: one write port, one registered read.
  always_ff @(posedge clk) begin
    if (cmd.mem_write && widx_in_range) begin
      mem[widx_ext[MEM_WORD_BITS-1:0]] <= wdata_r;
    end else if (cmd.clr_leaf) begin
      mem[slot_r] <= 64'd0;
    end
    if (cmd.rd_root || cmd.rd_next) begin
      mem_q_r <= mem[rd_slot];
      slot_r  <= rd_slot;
    end
  end

  // Root pointer register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= 52'd0;
    end else if (cfg_we) begin
      root_r <= cfg_wdata;
    end
  end

  // Item capture, result and output registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r  <= in_tuser;
      widx_r  <= in_tdata[15:0];
      wdata_r <= in_tdata[79:16];
      va_r    <= in_tdata[127:80];
    end
    if (cmd.res_load) begin
      res_phys_r   <= res_phys;
      res_status_r <= cmd.res_status;
    end
    if (cmd.out_load) begin
      out_phys_r   <= res_phys_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_tdata = {4'd0, out_phys_r};
  assign out_tuser = out_status_r;

endmodule

`default_nettype wire

>>> src/page_table_walker_core.sv
// ----------------------------------------------------------------------------
// page_table_walker_core: four-level page-table walker
// Writes table words, translates 48-bit virtual addresses and unmaps them
// over a table memory of 2^MEM_WORD_BITS 64-bit words.
//
//   channel  direction  fields (low bit first)
//   in       slave      tuser: kind; tdata: word_index, word_data, virt_addr
//   out      master     tuser: status; tdata: phys_addr
//   cfg      write      wdata: root_table_addr
//
// A write, an unknown kind, or a translate or unmap whose root table lies
// outside the memory goes from the start state straight to the finish state;
// any other translate or unmap walks in between, with up to four dependent
// reads of the single table memory read port, one per walk level.
// Reset clears the control state and the root pointer; the table memory is
// not cleared and must be written before it is walked.
// A stalled output holds the result in the output register; the next item
// is accepted meanwhile and waits in its final cycle until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module page_table_walker_core #(
  parameter int MEM_WORD_BITS = ptw_pkg::MEM_WORD_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [51:0]  cfg_wdata,   // root_table_addr
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,    // word_index, word_data, virt_addr
  input  wire logic [1:0]   in_tuser,    // kind
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [55:0]       out_tdata,   // phys_addr, zero padding
  output logic [1:0]        out_tuser    // status
);

  ptw_pkg::cmd_t cmd;
  ptw_pkg::sts_t sts;

  // Walk controller.
  ptw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Memory and result datapath.
  ptw_datapath #(
    .MEM_WORD_BITS (MEM_WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

>>> src/ptw_checker.sv
// ----------------------------------------------------------------------------
// ptw_checker: port-level checks of the page-table walker
// Watches the handshakes and result fields of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn before it was taken");

  // One item at a time: no acceptance right after an acceptance.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while another is being walked");

  // Only defined status codes are reported.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ptw_pkg::ST_WINDOW)
    else $error("undefined status code on a result");

  // A failed walk reports a zero address.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ptw_pkg::ST_OK |-> out_tdata == 56'd0)
    else $error("non-zero address on a failed result");

endmodule

bind page_table_walker_core ptw_checker u_ptw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking regression for page_table_walker_core
// Builds page tables item by item, then translates and unmaps virtual
// addresses under several root pointers and handshake patterns. Every result
// is compared with a software copy of the walk.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int         MEM_BITS    = ptw_pkg::MEM_WORD_BITS_DEF;
  localparam int         MEM_WORDS   = 1 << MEM_BITS;
  localparam longint     TABLE_TOTAL = 1 << (MEM_BITS - 9);
  localparam int         TABLE_POOL  = 24;
  localparam int         VA_POOL     = 24;
  localparam int         CYCLE_LIMIT = 200000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [51:0]      phys;
    ptw_pkg::status_t status;
  } page_result_t;

  // Shadow of the table memory and the root pointer, plus the results
  // still owed by the block, oldest first.
  class walk_ledger;
    bit [63:0]    table_words [MEM_WORDS];
    bit           word_set [MEM_WORDS];
    bit [51:0]    root_addr;
    page_result_t pending_results[$];
    int           errors;
    int           checked;
    int           n_write;
    int           n_translate;
    int           n_unmap;
    int           n_unused;
    int           translate_status [3];

    function new();
      root_addr = '0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Follows va from the root. Stops at the first word that was never
    // written and reports it in gap, with the level it belongs to.
    function ptw_pkg::status_t trace_walk(input bit [47:0] va, output int leaf,
                                          output bit huge, output int gap,
                                          output int gap_level);
      bit [51:0] tbl;
      bit [39:0] tno;
      bit [8:0]  idx;
      bit [63:0] entry;
      int        slot;
      tbl       = root_addr;
      leaf      = -1;
      huge      = 1'b0;
      gap       = -1;
      gap_level = 0;
      for (int lvl = 0; lvl < 4; lvl++) begin
        idx = 9'(va >> (39 - 9 * lvl));
        tno = tbl[51:12];
        if (tno >= TABLE_TOTAL) return ptw_pkg::ST_WINDOW;
        slot = int'(tno) * 512 + int'(idx);
        if (!word_set[slot]) begin
          gap       = slot;
          gap_level = lvl;
          return ptw_pkg::ST_OK;
        end
        entry = table_words[slot];
        if (lvl == 3) begin
          leaf = slot;
          return ptw_pkg::ST_OK;
        end
        if (!entry[0]) return ptw_pkg::ST_MISSING;
        // The page-size bit counts only in a PD entry.
        if (lvl == 2 && entry[7]) begin
          leaf = slot;
          huge = 1'b1;
          return ptw_pkg::ST_OK;
        end
        tbl = entry[51:0];
      end
      return ptw_pkg::ST_MISSING;
    endfunction

    // Applies one accepted item and queues the result it must produce.
    function void take_item(bit [1:0] kind, bit [15:0] idx, bit [63:0] data, bit [47:0] va);
      page_result_t res;
      int           leaf;
      int           gap;
      int           gap_level;
      bit           huge;
      bit [63:0]    entry;
      res.phys   = '0;
      res.status = ptw_pkg::ST_OK;
      case (kind)
        ptw_pkg::KIND_WRITE: begin
          if (int'(idx) < MEM_WORDS) begin
            table_words[idx] = data;
            word_set[idx]    = 1'b1;
          end
          n_write++;
        end
        ptw_pkg::KIND_TRANSLATE: begin
          res.status = trace_walk(va, leaf, huge, gap, gap_level);
          if (res.status == ptw_pkg::ST_OK) begin
            entry = table_words[leaf];
            if (huge) begin
              res.phys = {entry[51:21], va[20:0]};
            end else if (entry[0]) begin
              res.phys = {entry[51:12], va[11:0]};
            end else begin
              res.status = ptw_pkg::ST_MISSING;
            end
          end
          translate_status[res.status]++;
          n_translate++;
        end
        ptw_pkg::KIND_UNMAP: begin
          res.status = trace_walk(va, leaf, huge, gap, gap_level);
          // A huge PD entry is left as it is.
          if (res.status == ptw_pkg::ST_OK && !huge) table_words[leaf] = '0;
          n_unmap++;
        end
        default: begin
          n_unused++;
        end
      endcase
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [51:0] phys, logic [1:0] status);
      page_result_t want;
      if (pending_results.size() == 0) begin
        $error("Result with no item outstanding: phys_addr %h, status %0d", phys, status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (phys !== want.phys) begin
        $error("phys_addr mismatch: expected %h, actual %h", want.phys, phys);
        errors++;
      end
      if (status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         cfg_we     = 1'b0;
  logic [51:0]  cfg_wdata  = '0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata   = '0;   // word_index, word_data, virt_addr
  logic [1:0]   in_tuser   = '0;   // kind
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [55:0]  out_tdata;         // phys_addr, zero padding
  logic [1:0]   out_tuser;         // status

  walk_ledger   ledger;
  bit [47:0]    va_pool [VA_POOL];
  int           send_idle_pct = 0;
  int           stall_pct     = 0;
  int           items_sent    = 0;
  int           root_writes   = 0;
  int           cycle_count   = 0;

  page_table_walker_core #(
    .MEM_WORD_BITS(MEM_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("page_table_walker_core regression: fail");
      $finish;
    end
  end

  // The receiver stalls at random while a stall rate is set.
  always @(posedge clk) begin
    if (stall_pct == 0) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Results are checked at the edge that accepts them.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      ledger.check_result(out_tdata[51:0], out_tuser);
    end
  end

  // Offers one item, with random idle cycles first, and returns at the edge
  // that accepts it.
  task automatic send_item(input bit [1:0] kind, input bit [15:0] idx, input bit [63:0] data,
                           input bit [47:0] va);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {va, data, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ledger.take_item(kind, idx, data, va);
    items_sent++;
  endtask

  // Holds the input back until every result has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  task automatic write_root(input bit [51:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    ledger.root_addr = value;
    root_writes++;
    cfg_we <= 1'b0;
  endtask

  // Random table entry for a given walk level. Pointers mostly land in a few
  // shared tables so that walks overlap; some point just or far outside.
  function automatic bit [63:0] make_entry(int level);
    bit [63:0] e;
    bit [39:0] tno;
    int        r;
    e    = {$urandom, $urandom};
    r    = $urandom_range(99);
    e[0] = ($urandom_range(99) < 88);
    if (level == 2) e[7] = ($urandom_range(99) < 30);
    if (level < 2 || (level == 2 && !e[7])) begin
      if (r < 4) begin
        tno = 40'(TABLE_TOTAL);
      end else if (r < 8) begin
        tno = 40'({$urandom, $urandom}) | 40'h80_0000_0000;
      end else if (r < 12) begin
        tno = 40'(TABLE_TOTAL - 1);
      end else begin
        tno = 40'($urandom_range(TABLE_POOL - 1));
      end
      e[51:12] = tno;
    end
    return e;
  endfunction

  // Table indices drawn mostly from a handful of values so that addresses
  // share upper-level tables.
  function automatic bit [8:0] pick_index();
    int r;
    r = $urandom_range(9);
    if (r < 8) return 9'(r % 4);
    if (r == 8) return 9'h1FF;
    return 9'($urandom);
  endfunction

  task automatic fill_va_pool();
    for (int i = 0; i < VA_POOL; i++) begin
      va_pool[i] = {pick_index(), pick_index(), pick_index(), pick_index(), 12'($urandom)};
    end
  endtask

  // Writes any table word the walk of va would read before it is set, then
  // sends the walk itself.
  task automatic walk_item(input bit [1:0] kind, input bit [47:0] va);
    int leaf;
    int gap;
    int gap_level;
    bit huge;
    void'(ledger.trace_walk(va, leaf, huge, gap, gap_level));
    while (gap >= 0) begin
      send_item(ptw_pkg::KIND_WRITE, 16'(gap), make_entry(gap_level),
                48'({$urandom, $urandom}));
      void'(ledger.trace_walk(va, leaf, huge, gap, gap_level));
    end
    send_item(kind, 16'($urandom), {$urandom, $urandom}, va);
  endtask

  task automatic random_item();
    int               r;
    int               leaf;
    int               gap;
    int               gap_level;
    bit               huge;
    bit [47:0]        va;
    ptw_pkg::status_t st;
    r  = $urandom_range(99);
    va = ($urandom_range(99) < 88) ? va_pool[$urandom_range(VA_POOL - 1)]
                                   : 48'({$urandom, $urandom});
    if (r < 9) begin
      send_item(ptw_pkg::KIND_WRITE, 16'($urandom), {$urandom, $urandom},
                48'({$urandom, $urandom}));
    end else if (r < 12) begin
      send_item(KIND_UNUSED, 16'($urandom), {$urandom, $urandom}, va);
    end else if (r < 20) begin
      // Remap the leaf of a mapping that is fully built, so that unmapped
      // pages come back.
      st = ledger.trace_walk(va, leaf, huge, gap, gap_level);
      if (st == ptw_pkg::ST_OK && gap < 0) begin
        send_item(ptw_pkg::KIND_WRITE, 16'(leaf), make_entry(huge ? 2 : 3),
                  48'({$urandom, $urandom}));
      end else begin
        walk_item(ptw_pkg::KIND_TRANSLATE, va);
      end
    end else if (r < 80) begin
      walk_item(ptw_pkg::KIND_TRANSLATE, va);
    end else begin
      walk_item(ptw_pkg::KIND_UNMAP, va);
    end
  endtask

  // Hand-built tables under root 0: table 1 is the PDPT, 2 the PD, 3 the PT.
  task automatic directed_items();
    send_item(ptw_pkg::KIND_WRITE, 16'hFFFF, '1, '1);
    send_item(ptw_pkg::KIND_WRITE, 16'd0, 64'h1001, '0);
    // The PDPT page-size bit must be ignored.
    send_item(ptw_pkg::KIND_WRITE, 16'd512, 64'h2081, '0);
    send_item(ptw_pkg::KIND_WRITE, 16'd1024, 64'h3001, '0);
    send_item(ptw_pkg::KIND_WRITE, 16'd1536, 64'hFFFF_FFFF_FFFF_F001, '0);
    send_item(ptw_pkg::KIND_TRANSLATE, '0, '0, 48'hFFF);
    send_item(ptw_pkg::KIND_UNMAP, '0, '0, 48'h0);
    send_item(ptw_pkg::KIND_TRANSLATE, '0, '0, 48'h0);
    // Huge page with the highest base and offset.
    send_item(ptw_pkg::KIND_WRITE, 16'd1025, 64'h000F_FFFF_FFE0_0081, '0);
    send_item(ptw_pkg::KIND_TRANSLATE, '0, '0, 48'h3F_FFFF);
    send_item(ptw_pkg::KIND_UNMAP, '0, '0, 48'h3F_FFFF);
    // Missing PML4 and PDPT entries.
    send_item(ptw_pkg::KIND_WRITE, 16'd1, 64'h0, '0);
    send_item(ptw_pkg::KIND_TRANSLATE, '0, '0, 48'h1 << 39);
    send_item(ptw_pkg::KIND_WRITE, 16'd513, 64'h0, '0);
    send_item(ptw_pkg::KIND_TRANSLATE, '0, '0, 48'h1 << 30);
    // Next table just past the end of the memory.
    send_item(ptw_pkg::KIND_WRITE, 16'd2, (64'(TABLE_TOTAL) << 12) | 64'h1, '0);
    send_item(ptw_pkg::KIND_TRANSLATE, '0, '0, 48'h2 << 39);
    send_item(ptw_pkg::KIND_UNMAP, '0, '0, 48'h2 << 39);
    // Huge bit set on an absent PD entry.
    send_item(ptw_pkg::KIND_WRITE, 16'd1026, 64'h80, '0);
    send_item(ptw_pkg::KIND_TRANSLATE, '0, '0, 48'h2 << 21);
    send_item(KIND_UNUSED, '1, '1, '1);
    walk_item(ptw_pkg::KIND_TRANSLATE, '1);
  endtask

  task automatic run_phase(input bit [51:0] root, input int idle, input int stall,
                           input int count, input bit pause);
    int stop;
    drain();
    repeat (8) @(posedge clk);
    write_root(root);
    send_idle_pct = idle;
    stall_pct     = stall;
    fill_va_pool();
    stop = items_sent + count;
    while (items_sent < stop) begin
      random_item();
      if (pause && items_sent >= stop - count / 2) begin
        drain();
        pause = 1'b0;
      end
    end
  endtask

  initial begin
    ledger = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_root('0);
    directed_items();

    run_phase('0, 0, 0, 140, 1'b0);
    run_phase({40'($urandom_range(TABLE_TOTAL - 1)), 12'($urandom)}, 61, 0, 130, 1'b0);
    run_phase({40'(TABLE_TOTAL - 1), 12'hFFF}, 0, 61, 130, 1'b1);
    run_phase('1, 17, 17, 40, 1'b0);
    run_phase({40'(TABLE_TOTAL), 12'h000}, 0, 0, 30, 1'b0);
    run_phase({40'($urandom_range(TABLE_TOTAL - 1)), 12'($urandom)}, 17, 17, 130, 1'b0);
    run_phase({40'($urandom_range(7)), 12'($urandom)}, 61, 0, 100, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    $display("%0d items, %0d roots: %0d writes, %0d translates, %0d unmaps, %0d unused.",
             items_sent, root_writes, ledger.n_write, ledger.n_translate, ledger.n_unmap,
             ledger.n_unused);
    $display("Translates: %0d ok, %0d not present, %0d outside; %0d results checked.",
             ledger.translate_status[ptw_pkg::ST_OK],
             ledger.translate_status[ptw_pkg::ST_MISSING],
             ledger.translate_status[ptw_pkg::ST_WINDOW], ledger.checked);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("page_table_walker_core regression: pass");
    end else begin
      $display("page_table_walker_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> page_table_walker_core.f
src/ptw_pkg.sv
src/ptw_ctrl.sv
src/ptw_datapath.sv
src/page_table_walker_core.sv
src/ptw_checker.sv
test/tb.sv
